// ----- rtl/i2c_slave_event_fifo_macros.svh -----
// Assertion macros shared by the I2C slave event buffer.
`ifndef I2C_SLAVE_EVENT_FIFO_MACROS_SVH
`define I2C_SLAVE_EVENT_FIFO_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define I2CSEF_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("i2c slave event buffer: immediate check failed");

// The consequent must hold in the cycle after the antecedent.
`define I2CSEF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("i2c slave event buffer: next-cycle check failed");

`endif

// ----- rtl/i2csef_pkg.sv -----
// Types and constants of the I2C slave event buffer.
package i2csef_pkg;

  localparam logic [2:0] OP_EVENT = 3'd0;
  localparam logic [2:0] OP_PUSH  = 3'd1;
  localparam logic [2:0] OP_POP   = 3'd2;
  localparam logic [2:0] OP_CLRTX = 3'd3;
  localparam logic [2:0] OP_FLUSH = 3'd4;

  localparam logic [7:0] SC_RX_DATA_OWN  = 8'h80;
  localparam logic [7:0] SC_RX_DATA_GEN  = 8'h90;
  localparam logic [7:0] SC_TX_ADDR      = 8'hA8;
  localparam logic [7:0] SC_TX_DATA      = 8'hB8;
  localparam logic [7:0] SC_RX_NACK_OWN  = 8'h88;
  localparam logic [7:0] SC_RX_NACK_GEN  = 8'h98;
  localparam logic [7:0] SC_TX_LAST      = 8'hC8;
  localparam logic [7:0] SC_NO_INFO      = 8'hF8;
  localparam logic [7:0] SC_BUS_ERROR    = 8'h00;

  localparam logic [7:0] EMPTY_BYTE = 8'h88;

  localparam logic [1:0] ACT_NONE = 2'd0;
  localparam logic [1:0] ACT_ACK  = 2'd1;
  localparam logic [1:0] ACT_STOP = 2'd2;

  // Where the result byte comes from.
  localparam logic [1:0] SRC_ZERO  = 2'd0;
  localparam logic [1:0] SRC_EMPTY = 2'd1;
  localparam logic [1:0] SRC_RX    = 2'd2;
  localparam logic [1:0] SRC_TX    = 2'd3;

  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } ring_ctrl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } ring_status_t;

endpackage

// ----- rtl/i2csef_ring.sv -----
// Pre-increment byte ring held in a synchronous memory with registered read data.
module i2csef_ring #(
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  i2csef_pkg::ring_ctrl_t   ctrl,
  input  logic [7:0]               wr_data,
  output i2csef_pkg::ring_status_t status,
  output logic [7:0]               rd_data
);
  import i2csef_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  logic [7:0]    mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW-1:0] wr_ptr_next;
  logic [AW-1:0] rd_ptr_next;

  assign wr_ptr_next  = (wr_ptr == LAST) ? '0 : wr_ptr + AW'(1);
  assign rd_ptr_next  = (rd_ptr == LAST) ? '0 : rd_ptr + AW'(1);
  assign status.empty = (wr_ptr == rd_ptr);
  assign status.full  = (wr_ptr_next == rd_ptr);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else if (ctrl.clear) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (ctrl.push && !status.full) begin
        wr_ptr <= wr_ptr_next;
      end
      if (ctrl.pop && !status.empty) begin
        rd_ptr <= rd_ptr_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.push && !status.full && !ctrl.clear) begin
      mem[wr_ptr_next] <= wr_data;
    end
    if (ctrl.pop && !status.empty && !ctrl.clear) begin
      rd_data <= mem[rd_ptr_next];
    end
  end

endmodule

// ----- rtl/i2c_slave_event_fifo.sv -----
// Top level of the I2C slave event buffer: decode, result stage and output register.
// Each accepted request updates the ring pointers and issues its memory access at the
// edge where it is accepted, and the memory's registered read port loads the popped
// byte at that same edge. The output register takes the result from the result stage
// when that stage advances, which a held result can delay, and res_valid then rises.
// The stage after the memory and the output register overlap, so one
// request per cycle is taken while results are drained, and a held result stalls
// input only once both stages are full.
// The stores need no clearing after reset; only entries that have been written are read.
module i2c_slave_event_fifo #(
  parameter int RX_DEPTH = 16,
  parameter int TX_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] op,
  input  logic [7:0] status_code,
  input  logic [7:0] data_byte,
  output logic       res_valid,
  input  logic       res_ready,
  output logic [7:0] out_byte,
  output logic       out_valid,
  output logic [1:0] bus_action,
  output logic       rx_available,
  output logic       byte_dropped,
  output logic       rx_underflow
);
  import i2csef_pkg::*;

  ring_ctrl_t   rx_ctrl;
  ring_ctrl_t   tx_ctrl;
  ring_status_t rx_status;
  ring_status_t tx_status;
  logic [7:0]   rx_rd_data;
  logic [7:0]   tx_rd_data;

  logic       accept;
  logic       s1_adv;
  logic       s1_valid;
  logic [1:0] s1_src;
  logic       s1_ovalid;
  logic [1:0] s1_action;
  logic       s1_dropped;
  logic       s1_underflow;

  logic [1:0] src_next;
  logic       ovalid_next;
  logic [1:0] action_next;
  logic       dropped_next;
  logic       underflow_next;

  assign s1_adv   = s1_valid && (!res_valid || res_ready);
  assign in_ready = !s1_valid || s1_adv;
  assign accept   = in_valid && in_ready;

  always_comb begin
    rx_ctrl        = '0;
    tx_ctrl        = '0;
    src_next       = SRC_ZERO;
    ovalid_next    = 1'b0;
    action_next    = ACT_NONE;
    dropped_next   = 1'b0;
    underflow_next = 1'b0;
    case (op)
      OP_EVENT: begin
        case (status_code)
          SC_RX_DATA_OWN, SC_RX_DATA_GEN: begin
            rx_ctrl.push = accept;
            dropped_next = rx_status.full;
            action_next  = ACT_ACK;
          end
          SC_TX_ADDR, SC_TX_DATA: begin
            tx_ctrl.pop = accept;
            src_next    = tx_status.empty ? SRC_EMPTY : SRC_TX;
            ovalid_next = 1'b1;
            action_next = ACT_ACK;
          end
          SC_RX_NACK_OWN, SC_RX_NACK_GEN, SC_TX_LAST, SC_NO_INFO, SC_BUS_ERROR: begin
            action_next = ACT_STOP;
          end
          default: begin
            action_next = ACT_ACK;
          end
        endcase
      end
      OP_PUSH: begin
        tx_ctrl.push = accept;
        dropped_next = tx_status.full;
      end
      OP_POP: begin
        rx_ctrl.pop    = accept;
        src_next       = rx_status.empty ? SRC_EMPTY : SRC_RX;
        ovalid_next    = !rx_status.empty;
        underflow_next = rx_status.empty;
      end
      OP_CLRTX: begin
        tx_ctrl.clear = accept;
      end
      OP_FLUSH: begin
        rx_ctrl.clear = accept;
        tx_ctrl.clear = accept;
      end
      default: begin
      end
    endcase
  end

  i2csef_ring #(.DEPTH(RX_DEPTH)) u_rx_ring (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (rx_ctrl),
    .wr_data (data_byte),
    .status  (rx_status),
    .rd_data (rx_rd_data)
  );

  i2csef_ring #(.DEPTH(TX_DEPTH)) u_tx_ring (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (tx_ctrl),
    .wr_data (data_byte),
    .status  (tx_status),
    .rd_data (tx_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_src       <= src_next;
      s1_ovalid    <= ovalid_next;
      s1_action    <= action_next;
      s1_dropped   <= dropped_next;
      s1_underflow <= underflow_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_adv) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  // The ring pointers seen while a request sits in the result stage already
  // reflect that request and no later one, so they give the receive level.
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      case (s1_src)
        SRC_EMPTY: out_byte <= EMPTY_BYTE;
        SRC_RX:    out_byte <= rx_rd_data;
        SRC_TX:    out_byte <= tx_rd_data;
        default:   out_byte <= 8'h00;
      endcase
      out_valid    <= s1_ovalid;
      bus_action   <= s1_action;
      rx_available <= !rx_status.empty;
      byte_dropped <= s1_dropped;
      rx_underflow <= s1_underflow;
    end
  end

`include "i2c_slave_event_fifo_macros.svh"

  `I2CSEF_ASSERT_NEXT(a_accept_fills_stage, clk, rst, accept, s1_valid)
  `I2CSEF_ASSERT_NOW(a_underflow_no_byte, clk, rst, res_valid && rx_underflow, !out_valid && out_byte == EMPTY_BYTE)
  `I2CSEF_ASSERT_NOW(a_drop_no_byte, clk, rst, res_valid && byte_dropped, !out_valid && !rx_underflow)

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for the I2C slave event buffer with its receive and transmit rings.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import i2csef_pkg::*;

  localparam int RING_DEPTH = 16;
  localparam int PTR_W = $clog2(RING_DEPTH);
  localparam int RANDOM_REQUESTS = 550;
  localparam int DRAIN_AT = 300;
  localparam int LONG_STALL = 40;
  localparam int SETTLE_CYCLES = 10;

  // Status codes that only take the acknowledge path.
  localparam logic [7:0] SC_OWN_ADDR  = 8'h60;
  localparam logic [7:0] SC_GEN_CALL  = 8'h70;
  localparam logic [7:0] SC_TX_NACK   = 8'hC0;
  localparam logic [7:0] SC_STOP_SEEN = 8'hA0;
  localparam logic [7:0] SC_ALL_ONES  = 8'hFF;

  // Op codes the block ignores.
  localparam logic [2:0] OP_RSVD_FIRST = 3'd5;
  localparam logic [2:0] OP_RSVD_LAST  = 3'd7;

  typedef struct {
    logic [2:0] op;
    logic [7:0] code;
    logic [7:0] data;
    int         phase;
    bit         drain_first;
  } request_t;

  typedef struct packed {
    logic [7:0] obyte;
    logic       ovalid;
    logic [1:0] action;
    logic       avail;
    logic       dropped;
    logic       underflow;
  } response_t;

  logic       clk;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [2:0] op = OP_EVENT;
  logic [7:0] status_code = 8'h00;
  logic [7:0] data_byte = 8'h00;
  logic       res_valid;
  logic       res_ready = 1'b0;
  logic [7:0] out_byte;
  logic       out_valid;
  logic [1:0] bus_action;
  logic       rx_available;
  logic       byte_dropped;
  logic       rx_underflow;

  i2c_slave_event_fifo #(
    .RX_DEPTH(RING_DEPTH),
    .TX_DEPTH(RING_DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .op(op),
    .status_code(status_code),
    .data_byte(data_byte),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .out_byte(out_byte),
    .out_valid(out_valid),
    .bus_action(bus_action),
    .rx_available(rx_available),
    .byte_dropped(byte_dropped),
    .rx_underflow(rx_underflow)
  );

  request_t    request_queue[$];
  response_t   awaited_responses[$];
  int unsigned issued_cnt = 0;
  int unsigned checked_cnt = 0;
  int          idle_phase = 0;
  int          mismatches = 0;
  int          op_counts[8];
  int          drops_seen = 0;
  int          underflows_seen = 0;

  // Shadow copy of both rings.
  logic [7:0]       rx_mem[RING_DEPTH];
  logic [7:0]       tx_mem[RING_DEPTH];
  logic [PTR_W-1:0] rx_wr = '0;
  logic [PTR_W-1:0] rx_rd = '0;
  logic [PTR_W-1:0] tx_wr = '0;
  logic [PTR_W-1:0] tx_rd = '0;

  logic [7:0] known_codes[14] = '{
    SC_RX_DATA_OWN, SC_RX_DATA_GEN, SC_TX_ADDR, SC_TX_DATA, SC_RX_NACK_OWN,
    SC_RX_NACK_GEN, SC_TX_LAST, SC_NO_INFO, SC_BUS_ERROR, SC_OWN_ADDR,
    SC_GEN_CALL, SC_TX_NACK, SC_STOP_SEEN, SC_ALL_ONES
  };

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #200us;
    $display("timeout: %0d requests issued, %0d results checked", issued_cnt, checked_cnt);
    $display("tb_top NOT OK");
    $finish;
  end

  function automatic int idle_pct(int phase, bit sender);
    case (phase)
      0: return sender ? 6 : 51;
      1: return sender ? 51 : 6;
      default: return 0;
    endcase
  endfunction

  // Applies one request to the shadow rings and returns the response it should produce.
  function automatic response_t compute_slave_response(logic [2:0] rop, logic [7:0] code,
                                                       logic [7:0] data);
    response_t r;
    logic [PTR_W-1:0] nxt;
    r = '0;
    case (rop)
      OP_EVENT: begin
        case (code)
          SC_RX_DATA_OWN, SC_RX_DATA_GEN: begin
            nxt = rx_wr + 1'b1;
            if (nxt == rx_rd) begin
              r.dropped = 1'b1;
            end else begin
              rx_mem[nxt] = data;
              rx_wr = nxt;
            end
            r.action = ACT_ACK;
          end
          SC_TX_ADDR, SC_TX_DATA: begin
            if (tx_wr != tx_rd) begin
              tx_rd = tx_rd + 1'b1;
              r.obyte = tx_mem[tx_rd];
            end else begin
              r.obyte = EMPTY_BYTE;
            end
            r.ovalid = 1'b1;
            r.action = ACT_ACK;
          end
          SC_RX_NACK_OWN, SC_RX_NACK_GEN, SC_TX_LAST, SC_NO_INFO, SC_BUS_ERROR: begin
            r.action = ACT_STOP;
          end
          default: r.action = ACT_ACK;
        endcase
      end
      OP_PUSH: begin
        nxt = tx_wr + 1'b1;
        if (nxt == tx_rd) begin
          r.dropped = 1'b1;
        end else begin
          tx_mem[nxt] = data;
          tx_wr = nxt;
        end
      end
      OP_POP: begin
        if (rx_wr != rx_rd) begin
          rx_rd = rx_rd + 1'b1;
          r.obyte = rx_mem[rx_rd];
          r.ovalid = 1'b1;
        end else begin
          r.obyte = EMPTY_BYTE;
          r.underflow = 1'b1;
        end
      end
      OP_CLRTX: begin
        tx_wr = '0;
        tx_rd = '0;
      end
      OP_FLUSH: begin
        rx_wr = '0;
        rx_rd = '0;
        tx_wr = '0;
        tx_rd = '0;
      end
      default: ;
    endcase
    r.avail = (rx_wr != rx_rd);
    if (r.dropped) drops_seen++;
    if (r.underflow) underflows_seen++;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    mismatches++;
    $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d: %s is %0h, expected %0h",
                                checked_cnt, name, got, want));
    end
  endtask

  task automatic add_request(logic [2:0] rop, logic [7:0] code, logic [7:0] data);
    request_t req;
    int n;
    n = request_queue.size();
    req.op = rop;
    req.code = code;
    req.data = data;
    req.phase = (n < 200) ? 0 : (n < 380) ? 1 : 2;
    req.drain_first = (n == DRAIN_AT);
    request_queue.push_back(req);
    op_counts[rop]++;
  endtask

  function automatic logic [7:0] pick_code();
    if ($urandom_range(0, 3) == 0) return 8'($urandom);
    return known_codes[$urandom_range(0, 13)];
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom);
  endfunction

  // Driver: offers the next request, holding it steady until the block takes it.
  always @(posedge clk) begin : drive_requests
    bit          busy;
    bit          go;
    int unsigned owed;
    request_t    nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      busy = in_valid;
      owed = issued_cnt - checked_cnt;
      if (in_valid && in_ready) begin
        awaited_responses.push_back(compute_slave_response(op, status_code, data_byte));
        issued_cnt <= issued_cnt + 1;
        owed++;
        busy = 1'b0;
      end
      if (!busy) begin
        go = 1'b0;
        if (request_queue.size() > 0) begin
          nxt = request_queue[0];
          // A marked request waits until the block has answered everything before it.
          if (nxt.drain_first && owed != 0) go = 1'b0;
          else go = ($urandom_range(0, 99) >= idle_pct(nxt.phase, 1'b1));
        end
        if (go) begin
          void'(request_queue.pop_front());
          in_valid <= 1'b1;
          op <= nxt.op;
          status_code <= nxt.code;
          data_byte <= nxt.data;
          idle_phase <= nxt.phase;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random back-pressure, plus two long hold-offs that fill the block up.
  int unsigned stall_left = 0;
  int          stalls_done = 0;
  int unsigned stall_points[2] = '{120, 480};

  always @(posedge clk) begin : accept_results
    if (rst) begin
      res_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      res_ready <= 1'b0;
    end else if (stalls_done < 2 && issued_cnt >= stall_points[stalls_done]) begin
      stall_left <= LONG_STALL;
      stalls_done <= stalls_done + 1;
      res_ready <= 1'b0;
    end else begin
      res_ready <= ($urandom_range(0, 99) >= idle_pct(idle_phase, 1'b0));
    end
  end

  // Monitor: each accepted result is compared with the oldest outstanding prediction.
  always @(posedge clk) begin : check_results
    response_t want;
    if (!rst && res_valid && res_ready) begin
      checked_cnt <= checked_cnt + 1;
      if (awaited_responses.size() == 0) begin
        report_mismatch("result arrived with no request outstanding");
      end else begin
        want = awaited_responses.pop_front();
        check_field("out_byte", out_byte, want.obyte);
        check_field("out_valid", 8'(out_valid), 8'(want.ovalid));
        check_field("bus_action", 8'(bus_action), 8'(want.action));
        check_field("rx_available", 8'(rx_available), 8'(want.avail));
        check_field("byte_dropped", 8'(byte_dropped), 8'(want.dropped));
        check_field("rx_underflow", 8'(rx_underflow), 8'(want.underflow));
      end
    end
  end

  initial begin : stimulus
    int counted;
    int kind;
    int n;
    int m;
    logic [2:0] rop;

    foreach (op_counts[i]) op_counts[i] = 0;
    foreach (rx_mem[i]) begin
      rx_mem[i] = 8'h00;
      tx_mem[i] = 8'h00;
    end

    // Directed opening: empty rings, byte extremes, every stop code and the ignored ops.
    add_request(OP_POP, rand_byte(), rand_byte());
    add_request(OP_EVENT, SC_TX_ADDR, rand_byte());
    add_request(OP_EVENT, SC_RX_DATA_OWN, 8'h00);
    add_request(OP_EVENT, SC_RX_DATA_GEN, SC_ALL_ONES);
    add_request(OP_PUSH, 8'h00, SC_ALL_ONES);
    add_request(OP_PUSH, SC_ALL_ONES, 8'h00);
    add_request(OP_EVENT, SC_TX_DATA, rand_byte());
    add_request(OP_EVENT, SC_TX_ADDR, rand_byte());
    add_request(OP_EVENT, SC_RX_NACK_OWN, rand_byte());
    add_request(OP_EVENT, SC_RX_NACK_GEN, rand_byte());
    add_request(OP_EVENT, SC_TX_LAST, rand_byte());
    add_request(OP_EVENT, SC_NO_INFO, rand_byte());
    add_request(OP_EVENT, SC_BUS_ERROR, rand_byte());
    add_request(OP_EVENT, SC_ALL_ONES, rand_byte());
    add_request(OP_POP, rand_byte(), rand_byte());
    add_request(OP_POP, rand_byte(), rand_byte());
    add_request(OP_POP, rand_byte(), rand_byte());
    add_request(OP_PUSH, rand_byte(), rand_byte());
    add_request(OP_CLRTX, rand_byte(), rand_byte());
    add_request(OP_EVENT, SC_TX_DATA, rand_byte());
    add_request(OP_EVENT, SC_RX_DATA_OWN, rand_byte());
    add_request(OP_FLUSH, rand_byte(), rand_byte());
    add_request(OP_POP, rand_byte(), rand_byte());
    for (logic [3:0] k = {1'b0, OP_RSVD_FIRST}; k <= {1'b0, OP_RSVD_LAST}; k++) begin
      add_request(k[2:0], rand_byte(), rand_byte());
    end

    // Random part: mostly fill-and-drain bursts so that both rings reach full and empty.
    counted = 0;
    while (counted < RANDOM_REQUESTS) begin
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
        n = $urandom_range(1, RING_DEPTH + 3);
        m = $urandom_range(0, n + 2);
        repeat (n) begin
          add_request(OP_EVENT, $urandom_range(0, 1) ? SC_RX_DATA_OWN : SC_RX_DATA_GEN,
                      rand_byte());
        end
        repeat (m) add_request(OP_POP, rand_byte(), rand_byte());
        counted += n + m;
      end else if (kind < 60) begin
        n = $urandom_range(1, RING_DEPTH + 3);
        m = $urandom_range(0, n + 2);
        repeat (n) add_request(OP_PUSH, rand_byte(), rand_byte());
        repeat (m) begin
          add_request(OP_EVENT, $urandom_range(0, 1) ? SC_TX_ADDR : SC_TX_DATA, rand_byte());
        end
        counted += n + m;
      end else if (kind < 85) begin
        rop = 3'($urandom_range(OP_EVENT, OP_POP));
        add_request(rop, pick_code(), rand_byte());
        counted++;
      end else if (kind < 93) begin
        add_request($urandom_range(0, 1) ? OP_CLRTX : OP_FLUSH, rand_byte(), rand_byte());
        counted++;
      end else if (kind < 97) begin
        add_request(OP_EVENT, rand_byte(), rand_byte());
        counted++;
      end else begin
        add_request(3'($urandom_range(OP_RSVD_FIRST, OP_RSVD_LAST)), rand_byte(), rand_byte());
      end
    end
    n = request_queue.size();

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Every request, ignored ones included, yields exactly one result.
    while (checked_cnt < n) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (awaited_responses.size() != 0) begin
      report_mismatch($sformatf("%0d predicted results never arrived",
                                awaited_responses.size()));
    end

    $display("covered %0d requests: %0d bus events, %0d pushes, %0d pops, %0d clears, %0d flushes,",
             n, op_counts[OP_EVENT], op_counts[OP_PUSH], op_counts[OP_POP],
             op_counts[OP_CLRTX], op_counts[OP_FLUSH]);
    $display("%0d ignored ops; %0d full-ring drops, %0d empty pops, %0d mismatches",
             n - op_counts[OP_EVENT] - op_counts[OP_PUSH] - op_counts[OP_POP]
               - op_counts[OP_CLRTX] - op_counts[OP_FLUSH],
             drops_seen, underflows_seen, mismatches);
    if (mismatches == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
